>>> sv/sps_fs_pkg.sv
// Shared types, codes and helpers for the SPS frame-size parser.
// No dependencies; every other file of the block imports this package.
package sps_fs_pkg;

  typedef struct packed {
    logic [7:0] sps_byte;
    logic       first_byte;
    logic       last_byte;
  } sps_in_t;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [7:0]  profile_code;
    logic [1:0]  parse_status;
  } sps_out_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_LONG_CODE = 2'd3;

  localparam logic [4:0] MAX_LEADING_ZEROS = 5'd31;
  localparam int         QUEUE_DEPTH       = 2;

  typedef enum logic [5:0] {
    PH_IDLE, PH_HEADER, PH_PROFILE, PH_CONSTRAINT, PH_SPS_ID, PH_CHROMA,
    PH_SEPARATE, PH_DEPTH_LUMA, PH_DEPTH_CHROMA, PH_BYPASS, PH_MATRIX,
    PH_LIST_FLAG, PH_DELTA, PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB,
    PH_ALWAYS_ZERO, PH_OFF_NONREF, PH_OFF_TB, PH_CYCLE_LEN, PH_OFF_REF,
    PH_NUM_REF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FRAME_MBS, PH_MBAFF,
    PH_DIRECT, PH_CROP_FLAG, PH_CROP_L, PH_CROP_R, PH_CROP_T, PH_CROP_B,
    PH_FINISH
  } phase_t;

  // True for fields coded as unsigned or signed Exp-Golomb values.
  function automatic logic is_code_phase(input phase_t p);
    logic r;
    unique case (p)
      PH_SPS_ID, PH_CHROMA, PH_DEPTH_LUMA, PH_DEPTH_CHROMA, PH_DELTA,
      PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB, PH_OFF_NONREF, PH_OFF_TB,
      PH_CYCLE_LEN, PH_OFF_REF, PH_NUM_REF, PH_WIDTH, PH_HEIGHT,
      PH_CROP_L, PH_CROP_R, PH_CROP_T, PH_CROP_B: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Signed Exp-Golomb value modulo 256, from the code value plus one.
  function automatic logic [7:0] se_low8(input logic [31:0] vp1);
    return vp1[0] ? (8'd0 - vp1[8:1]) : vp1[8:1];
  endfunction

endpackage

>>> sv/h264_sps_frame_size_parser.sv
// Top level of the H.264 SPS frame-size parser: input queue plus bit-serial
// parser. Depends on sps_fs_pkg, sps_fs_queue and sps_fs_parse.
//
//   Channel  Ports                           Transaction
//   input    in_valid, in_stall, in_data     one byte of an SPS unit
//   output   out_valid, out_stall, out_data  size, profile, status of a unit
//
// The field sequencer consumes a single bit per clock unless a result is
// blocked at the output, so each accepted byte is parsed bit by bit; a byte
// ignored between units is popped without being parsed, and a unit that
// reaches the end of the crop fields takes a finish step for the size check.
// Reset (rst_n low, synchronous) empties the queue and leaves the parser idle.
// A two-entry queue takes new bytes while the parser works; a held result
// stalls the parser only when the next result is ready to be written.
module h264_sps_frame_size_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sps_fs_pkg::sps_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sps_fs_pkg::sps_out_t out_data
);
  import sps_fs_pkg::*;

  logic    q_valid, q_pop;
  sps_in_t q_data;

  // Front: buffers bytes so the host is held only when the queue is full.
  sps_fs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // Back: walks the SPS fields and produces one result per unit.
  sps_fs_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/sps_fs_queue.sv
// Front part of the SPS frame-size parser: a short input queue.
// Depends on sps_fs_pkg for the input transaction type.
module sps_fs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sps_fs_pkg::sps_in_t in_data,
  output logic               q_valid,
  output sps_fs_pkg::sps_in_t q_data,
  input  logic               q_pop
);
  import sps_fs_pkg::*;

  sps_in_t    mem_r [QUEUE_DEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

endmodule

>>> sv/sps_fs_parse.sv
// Back part of the SPS frame-size parser: bit-serial field sequencer with
// Exp-Golomb decoding and the result register. Depends on sps_fs_pkg.
module sps_fs_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sps_fs_pkg::sps_in_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sps_fs_pkg::sps_out_t out_data
);
  import sps_fs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  skip_r, skip_nxt, zrun_r, zrun_nxt;
  logic        sfx_r, sfx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  prof_r, prof_nxt;
  logic [3:0]  lidx_r, lidx_nxt;
  logic [6:0]  ent_r, ent_nxt;
  logic [7:0]  prior_r, prior_nxt;
  logic        prog_r, prog_nxt;
  logic [31:0] wmb_r, wmb_nxt, hu_r, hu_nxt, offl_r, offl_nxt;
  logic [34:0] ch_r, ch_nxt, cv_r, cv_nxt;
  logic        busy_r, busy_nxt, last_r, last_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        out_valid_r;
  sps_out_t    out_r;

  logic        b, code_done, emit, adv, out_free, ended;
  logic [1:0]  em_status;
  logic [7:0]  em_prof;
  logic [31:0] vp1, v32;
  logic [32:0] c2;
  logic [7:0]  up;
  logic [6:0]  ent_dec;
  logic [35:0] fw;
  logic [36:0] fh;
  logic [35:0] cv;
  logic [38:0] dw, dh;
  logic        size_ok;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign b         = byte_r[bit_r];

  always_comb begin
    fw      = {wmb_r, 4'b0};
    fh      = prog_r ? {1'b0, hu_r, 4'b0} : {hu_r, 5'b0};
    cv      = prog_r ? {1'b0, cv_r} : {cv_r, 1'b0};
    dw      = 39'(fw) - 39'(ch_r);
    dh      = 39'(fh) - 39'(cv);
    size_ok = !dw[38] && (dw[37:16] == 22'd0) && !dh[38] && (dh[37:16] == 22'd0);
  end

  always_comb begin
    phase_nxt = phase_r;  skip_nxt = skip_r;  zrun_nxt = zrun_r;
    sfx_nxt = sfx_r;      acc_nxt = acc_r;    prof_nxt = prof_r;
    lidx_nxt = lidx_r;    ent_nxt = ent_r;    prior_nxt = prior_r;
    prog_nxt = prog_r;    wmb_nxt = wmb_r;    hu_nxt = hu_r;
    offl_nxt = offl_r;    ch_nxt = ch_r;      cv_nxt = cv_r;
    busy_nxt = busy_r;    last_nxt = last_r;  byte_nxt = byte_r;
    bit_nxt = bit_r;
    emit = 1'b0;  em_status = ST_OK;  code_done = 1'b0;  vp1 = 32'd1;
    ended = 1'b0;  q_pop = 1'b0;
    v32 = 32'd0;  c2 = 33'd0;  up = 8'd0;  ent_dec = 7'd0;

    if (busy_r && phase_r == PH_FINISH) begin
      emit = 1'b1;
      em_status = size_ok ? ST_OK : ST_RANGE;
      ended = 1'b1;
    end else if (busy_r) begin
      if (is_code_phase(phase_r)) begin
        if (!sfx_r) begin
          if (!b) begin
            if (zrun_r >= MAX_LEADING_ZEROS) begin
              emit = 1'b1;  em_status = ST_LONG_CODE;  ended = 1'b1;
            end else begin
              zrun_nxt = zrun_r + 5'd1;
            end
          end else if (zrun_r == 5'd0) begin
            code_done = 1'b1;  vp1 = 32'd1;
          end else begin
            sfx_nxt = 1'b1;  skip_nxt = zrun_r;  acc_nxt = 32'd1;
          end
        end else begin
          acc_nxt  = {acc_r[30:0], b};
          skip_nxt = skip_r - 5'd1;
          if (skip_r == 5'd1) begin
            code_done = 1'b1;  vp1 = acc_nxt;
            sfx_nxt = 1'b0;  zrun_nxt = 5'd0;  acc_nxt = 32'd0;
          end
        end
        v32     = vp1 - 32'd1;
        c2      = {vp1, 1'b0} - 33'd2;
        up      = prior_r + se_low8(vp1);
        ent_dec = (ent_r != 7'd0) ? ent_r - 7'd1 : 7'd0;
        if (code_done) begin
          unique case (phase_r)
            PH_SPS_ID: phase_nxt = (prof_r == 8'd100 || prof_r == 8'd110 ||
                                    prof_r == 8'd122 || prof_r == 8'd144)
                                   ? PH_CHROMA : PH_FRAME_NUM;
            PH_CHROMA: phase_nxt = (vp1 == 32'd4) ? PH_SEPARATE : PH_DEPTH_LUMA;
            PH_DEPTH_LUMA: phase_nxt = PH_DEPTH_CHROMA;
            PH_DEPTH_CHROMA: phase_nxt = PH_BYPASS;
            PH_DELTA: begin
              if (up != 8'd0) prior_nxt = up;
              ent_nxt = ent_dec;
              if (up == 8'd0 || ent_dec == 7'd0) begin
                lidx_nxt  = lidx_r + 4'd1;
                phase_nxt = (lidx_nxt >= 4'd8) ? PH_FRAME_NUM : PH_LIST_FLAG;
              end
            end
            PH_FRAME_NUM: phase_nxt = PH_POC_TYPE;
            PH_POC_TYPE: begin
              if (vp1 == 32'd1) phase_nxt = PH_POC_LSB;
              else if (vp1 == 32'd2) phase_nxt = PH_ALWAYS_ZERO;
              else phase_nxt = PH_NUM_REF;
            end
            PH_POC_LSB: phase_nxt = PH_NUM_REF;
            PH_OFF_NONREF: phase_nxt = PH_OFF_TB;
            PH_OFF_TB: phase_nxt = PH_CYCLE_LEN;
            PH_CYCLE_LEN: begin
              offl_nxt  = v32;
              phase_nxt = (v32 == 32'd0) ? PH_NUM_REF : PH_OFF_REF;
            end
            PH_OFF_REF: begin
              offl_nxt = offl_r - 32'd1;
              if (offl_r == 32'd1) phase_nxt = PH_NUM_REF;
            end
            PH_NUM_REF: phase_nxt = PH_GAPS;
            PH_WIDTH: begin wmb_nxt = vp1; phase_nxt = PH_HEIGHT; end
            PH_HEIGHT: begin hu_nxt = vp1; phase_nxt = PH_FRAME_MBS; end
            PH_CROP_L: begin ch_nxt = 35'(c2); phase_nxt = PH_CROP_R; end
            PH_CROP_R: begin ch_nxt = ch_r + 35'(c2); phase_nxt = PH_CROP_T; end
            PH_CROP_T: begin cv_nxt = 35'(c2); phase_nxt = PH_CROP_B; end
            PH_CROP_B: begin cv_nxt = cv_r + 35'(c2); phase_nxt = PH_FINISH; end
            default: begin emit = 1'b1; em_status = ST_TRUNCATED; ended = 1'b1; end
          endcase
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            skip_nxt = skip_r - 5'd1;
            if (skip_r == 5'd1) begin phase_nxt = PH_PROFILE; skip_nxt = 5'd8; end
          end
          PH_PROFILE: begin
            prof_nxt = {prof_r[6:0], b};
            skip_nxt = skip_r - 5'd1;
            if (skip_r == 5'd1) begin phase_nxt = PH_CONSTRAINT; skip_nxt = 5'd16; end
          end
          PH_CONSTRAINT: begin
            skip_nxt = skip_r - 5'd1;
            if (skip_r == 5'd1) phase_nxt = PH_SPS_ID;
          end
          PH_SEPARATE: phase_nxt = PH_DEPTH_LUMA;
          PH_BYPASS: phase_nxt = PH_MATRIX;
          PH_MATRIX: begin
            if (b) begin lidx_nxt = 4'd0; phase_nxt = PH_LIST_FLAG; end
            else phase_nxt = PH_FRAME_NUM;
          end
          PH_LIST_FLAG: begin
            if (b) begin
              ent_nxt   = (lidx_r < 4'd6) ? 7'd16 : 7'd64;
              prior_nxt = 8'd8;
              phase_nxt = PH_DELTA;
            end else begin
              lidx_nxt  = lidx_r + 4'd1;
              phase_nxt = (lidx_nxt >= 4'd8) ? PH_FRAME_NUM : PH_LIST_FLAG;
            end
          end
          PH_ALWAYS_ZERO: phase_nxt = PH_OFF_NONREF;
          PH_GAPS: phase_nxt = PH_WIDTH;
          PH_FRAME_MBS: begin
            prog_nxt  = b;
            phase_nxt = b ? PH_DIRECT : PH_MBAFF;
          end
          PH_MBAFF: phase_nxt = PH_DIRECT;
          PH_DIRECT: phase_nxt = PH_CROP_FLAG;
          PH_CROP_FLAG: phase_nxt = b ? PH_CROP_L : PH_FINISH;
          default: begin emit = 1'b1; em_status = ST_TRUNCATED; ended = 1'b1; end
        endcase
      end
      bit_nxt = bit_r - 3'd1;
      if (!ended && phase_nxt != PH_FINISH && bit_r == 3'd0) begin
        busy_nxt = 1'b0;
        if (last_r) begin
          emit = 1'b1;  em_status = ST_TRUNCATED;  ended = 1'b1;
        end
      end
    end

    if (ended) begin
      phase_nxt = PH_IDLE;
      busy_nxt  = 1'b0;
    end

    // The reported profile includes a profile bit taken in this very cycle.
    em_prof = prof_nxt;
    adv = !emit || out_free;

    if (q_valid && !busy_nxt && adv) begin
      q_pop = 1'b1;
      if (q_data.first_byte) begin
        phase_nxt = PH_HEADER;  skip_nxt = 5'd8;  zrun_nxt = 5'd0;
        sfx_nxt = 1'b0;   acc_nxt = 32'd0;  prof_nxt = 8'd0;
        lidx_nxt = 4'd0;  ent_nxt = 7'd0;   prior_nxt = 8'd8;
        prog_nxt = 1'b1;  wmb_nxt = 32'd0;  hu_nxt = 32'd0;
        offl_nxt = 32'd0; ch_nxt = 35'd0;   cv_nxt = 35'd0;
      end
      if (q_data.first_byte || phase_nxt != PH_IDLE) begin
        busy_nxt = 1'b1;
        byte_nxt = q_data.sps_byte;
        last_nxt = q_data.last_byte;
        bit_nxt  = 3'd7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sfx_r       <= 1'b0;
      zrun_r      <= 5'd0;
      skip_r      <= 5'd0;
    end else begin
      if (adv) begin
        phase_r <= phase_nxt;
        busy_r  <= busy_nxt;
        sfx_r   <= sfx_nxt;
        zrun_r  <= zrun_nxt;
        skip_r  <= skip_nxt;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;   prof_r <= prof_nxt;   lidx_r <= lidx_nxt;
      ent_r <= ent_nxt;   prior_r <= prior_nxt; prog_r <= prog_nxt;
      wmb_r <= wmb_nxt;   hu_r <= hu_nxt;       offl_r <= offl_nxt;
      ch_r <= ch_nxt;     cv_r <= cv_nxt;       last_r <= last_nxt;
      byte_r <= byte_nxt; bit_r <= bit_nxt;
    end
    if (emit && out_free) begin
      out_r.frame_width  <= (em_status == ST_OK) ? dw[15:0] : 16'd0;
      out_r.frame_height <= (em_status == ST_OK) ? dh[15:0] : 16'd0;
      out_r.profile_code <= em_prof;
      out_r.parse_status <= em_status;
    end
  end

  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINISH |-> busy_r) else $error("finish step without a byte");
  a_suffix_count: assert property (@(posedge clk) disable iff (!rst_n)
    sfx_r |-> skip_r != 5'd0) else $error("suffix active with no bits left");
  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LIST_FLAG |-> lidx_r < 4'd8) else $error("scaling list index overrun");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !out_free |=> $stable(phase_r)) else $error("parser moved while result blocked");

endmodule
